@@ rtl/core/x86pr_pkg.sv @@
// x86pr_pkg: shared types and constants for the prologue relocator
// no dependencies

package x86pr_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_CLASS,
      ST_EMIT_RD,
      ST_SEARCH,
      ST_CALC,
      ST_OUT
   } state_type;

   localparam logic [2:0] KIND_PLAIN = 3'd0;
   localparam logic [2:0] KIND_RIP   = 3'd1;
   localparam logic [2:0] KIND_INT   = 3'd2;
   localparam logic [2:0] KIND_JMP   = 3'd3;
   localparam logic [2:0] KIND_JCC   = 3'd4;
   localparam logic [2:0] KIND_NEAR  = 3'd5;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_SHORT   = 2'd1;
   localparam logic [1:0] STAT_RANGE   = 2'd2;
   localparam logic [1:0] STAT_MISSING = 2'd3;

   localparam int KEEP_LIMIT = 14;

   localparam logic [7:0] OP_CALL   = 8'hE8;
   localparam logic [7:0] OP_JMP8   = 8'hEB;
   localparam logic [7:0] OP_JMP32  = 8'hE9;
   localparam logic [7:0] OP_ESC    = 8'h0F;
   localparam logic [7:0] OP_ADD10  = 8'h10;

   // attribute word: len, b0, b1, rip, dpos, ipos
   typedef struct packed {
      logic [3:0] ipos;
      logic [3:0] dpos;
      logic       rip;
      logic [7:0] b1;
      logic [7:0] b0;
      logic [3:0] len;
   } attr_type;

   function automatic logic is_branch(input logic [7:0] b0, input logic [7:0] b1);
      is_branch = (b0 == OP_CALL) || (b0 == OP_JMP8) || (b0 == OP_JMP32) ||
                  (b0[7:4] == 4'h7) || (b0 == OP_ESC && b1[7:4] == 4'h8);
   endfunction

endpackage

@@ rtl/core/x86pr_ram.sv @@
// x86pr_ram: generic single-port-write, single-read ram with registered read
// no dependencies

module x86pr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/core/x86_prologue_relocator.sv @@
// x86_prologue_relocator: plans relocation of the first decoded instructions
// depends on x86pr_pkg and x86pr_ram
// loading: one item per cycle, no result unless tlast is set
// run on tlast: scan the kept entries, classify each kept entry, then per result
// read the stored entry, search for the internal target when needed and
// build the item; each store has one read port, the search uses its own copies
// reset: synchronous, clears control state, relocation_base and counters

module x86_prologue_relocator #(
   parameter int MAX_INSTS  = 32,
   parameter int MIN_STOLEN = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [63:0]  csr_wr_data,     // relocation_base
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: inst_address, inst_length, first_byte, second_byte, uses_rip_base,
   // displacement, branch_target, disp_position, imm_position, zero fill
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,       // last_inst
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: inst_index, tramp_offset, patch_kind, new_length, patch_position,
   // patch_value, new_opcode_lo, new_opcode_hi, status, stolen_bytes,
   // relocated_length
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast        // last_result
);
   import x86pr_pkg::*;

   localparam int AW = $clog2(MAX_INSTS);
   localparam int CW = $clog2(MAX_INSTS + 1);

   // input fields
   logic [63:0] in_addr, in_btgt;
   logic [3:0]  in_len, in_dpos, in_ipos;
   logic [7:0]  in_b0, in_b1;
   logic        in_rip;
   logic [31:0] in_disp;
   assign in_addr = req_tdata[63:0];
   assign in_len  = req_tdata[67:64];
   assign in_b0   = req_tdata[75:68];
   assign in_b1   = req_tdata[83:76];
   assign in_rip  = req_tdata[84];
   assign in_disp = req_tdata[116:85];
   assign in_btgt = req_tdata[180:117];
   assign in_dpos = req_tdata[184:181];
   assign in_ipos = req_tdata[188:185];

   state_type state_ff, state_in;
   logic [63:0] base_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [5:0]  total_ff, total_in;
   logic [4:0]  kept_ff, kept_in;
   logic [4:0]  idx_ff, idx_in;       // walking index
   logic [4:0]  sidx_ff, sidx_in;     // search index
   logic        phase_ff, phase_in;
   logic [7:0]  off_ff, off_in;       // running trampoline offset
   logic [7:0]  rel_ff, rel_in;
   logic [63:0] start_ff, start_in;
   logic [63:0] p_ff, p_in;
   logic [2:0]  kind_ff, kind_in;
   logic [3:0]  nl_ff, nl_in;
   logic [7:0]  toff_ff, toff_in;
   logic [7:0]  jofs_ff, jofs_in;
   logic        found_ff, found_in;
   logic [87:0] out_ff, out_in;
   logic        olast_ff, olast_in;
   logic [4:0]  oidx_ff, oidx_in;

   // stores
   logic          st_we, os_we;
   logic [AW-1:0] st_wa, rd_a, os_wa, srch_a;
   logic [63:0]   tgt_wd, addr_rd, tgt_rd, saddr_rd;
   attr_type      attr_wd, attr_rd;
   logic [14:0]   os_wd, os_rd;       // kind, new length, offset
   logic [7:0]    so_rd;
   logic [14:0]   so_full;

   assign st_we  = (state_ff == ST_LOAD) && req_tvalid && (count_ff < CW'(MAX_INSTS));
   assign st_wa  = count_ff[AW-1:0];
   assign tgt_wd = in_rip ? in_addr + {60'd0, in_len} + {{32{in_disp[31]}}, in_disp}
                          : in_btgt;
   assign attr_wd = '{ipos: in_ipos, dpos: in_dpos, rip: in_rip, b1: in_b1,
                      b0: in_b0, len: in_len};
   assign rd_a   = AW'(idx_in);
   assign srch_a = AW'(sidx_in);
   assign so_rd  = so_full[7:0];

   x86pr_ram #(.WIDTH(64), .DEPTH(MAX_INSTS)) u_addr (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(in_addr),
      .rd_addr(rd_a), .rd_data(addr_rd));
   x86pr_ram #(.WIDTH(64), .DEPTH(MAX_INSTS)) u_saddr (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(in_addr),
      .rd_addr(srch_a), .rd_data(saddr_rd));
   x86pr_ram #(.WIDTH(64), .DEPTH(MAX_INSTS)) u_tgt (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(tgt_wd),
      .rd_addr(rd_a), .rd_data(tgt_rd));
   x86pr_ram #(.WIDTH($bits(attr_type)), .DEPTH(MAX_INSTS)) u_attr (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(attr_wd),
      .rd_addr(rd_a), .rd_data(attr_rd));
   x86pr_ram #(.WIDTH(15), .DEPTH(MAX_INSTS)) u_ofs (
      .clock, .wr_en(os_we), .wr_addr(os_wa), .wr_data(os_wd),
      .rd_addr(rd_a), .rd_data(os_rd));
   x86pr_ram #(.WIDTH(15), .DEPTH(MAX_INSTS)) u_sofs (
      .clock, .wr_en(os_we), .wr_addr(os_wa), .wr_data(os_wd),
      .rd_addr(srch_a), .rd_data(so_full));

   // shared 64-bit subtractor used for range check and internal test
   logic [63:0] sub_a, sub_b, sub_r;
   assign sub_r = sub_a - sub_b;

   logic [3:0]  cls_nl;
   logic [2:0]  cls_kind;
   logic [63:0] span;
   logic [63:0] s_chk;
   logic [7:0]  d8;
   logic [7:0]  lo_v, hi_v;
   logic [3:0]  pos_v;
   logic [31:0] val_v;
   logic [1:0]  st_v;
   logic [7:0]  rel_v;

   assign span = {58'd0, total_ff};
   assign s_chk = p_ff + 64'h8000_0000;
   assign d8 = jofs_ff - (toff_ff + {4'd0, nl_ff});

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      kept_in  = kept_ff;
      idx_in   = idx_ff;
      sidx_in  = sidx_ff;
      phase_in = phase_ff;
      off_in   = off_ff;
      rel_in   = rel_ff;
      start_in = start_ff;
      p_in     = p_ff;
      kind_in  = kind_ff;
      nl_in    = nl_ff;
      toff_in  = toff_ff;
      jofs_in  = jofs_ff;
      found_in = found_ff;
      out_in   = out_ff;
      olast_in = olast_ff;
      oidx_in  = oidx_ff;
      os_we    = 1'b0;
      os_wa    = AW'(idx_ff);
      os_wd    = '0;
      sub_a    = tgt_rd;
      sub_b    = start_ff;
      cls_kind = KIND_PLAIN;
      cls_nl   = attr_rd.len;
      lo_v = '0; hi_v = '0; pos_v = '0; val_v = '0; st_v = STAT_OK; rel_v = rel_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (st_we) count_in = count_ff + 1'b1;
               if (req_tlast) begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
                  phase_in = 1'b0;
                  total_in = '0;
                  kept_in  = '0;
               end
            end
         end
         // sum lengths until enough bytes are kept, else report too few bytes
         ST_SCAN: begin
            if (!phase_ff) begin
               if (kept_ff < 5'(KEEP_LIMIT) && CW'(kept_ff) < count_ff &&
                   total_ff < 6'(MIN_STOLEN)) begin
                  phase_in = 1'b1;
               end else if (total_ff < 6'(MIN_STOLEN)) begin
                  out_in   = {8'd0, total_ff, STAT_SHORT, 72'd0};
                  olast_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  idx_in   = '0;
                  off_in   = '0;
                  rel_in   = '0;
                  state_in = ST_CLASS;
               end
            end else begin
               if (kept_ff == 5'd0) start_in = addr_rd;
               total_in = total_ff + {2'd0, attr_rd.len};
               kept_in  = kept_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               phase_in = 1'b0;
            end
         end
         // classify each kept entry and lay out offsets
         ST_CLASS: begin
            if (!phase_ff) begin
               if (idx_ff == kept_ff) begin
                  idx_in   = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               if (attr_rd.rip) begin
                  cls_kind = KIND_RIP;
               end else if (is_branch(attr_rd.b0, attr_rd.b1)) begin
                  // inside [start, start + total) without wrapping past the top
                  if (tgt_rd >= start_ff && sub_r < span && span <= ~start_ff)
                     cls_kind = KIND_INT;
                  else if (attr_rd.b0 == OP_JMP8) begin
                     cls_kind = KIND_JMP; cls_nl = 4'd5;
                  end else if (attr_rd.b0[7:4] == 4'h7) begin
                     cls_kind = KIND_JCC; cls_nl = 4'd6;
                  end else cls_kind = KIND_NEAR;
               end
               os_we    = 1'b1;
               os_wd    = {cls_kind, cls_nl, off_ff};
               off_in   = off_ff + {4'd0, cls_nl};
               idx_in   = idx_ff + 1'b1;
               phase_in = 1'b0;
            end
         end
         // stored entry is readable now; prepare offset math
         ST_EMIT_RD: begin
            kind_in  = os_rd[14:12];
            nl_in    = os_rd[11:8];
            toff_in  = os_rd[7:0];
            sub_a    = tgt_rd;
            sub_b    = base_ff + {56'd0, os_rd[7:0]} + {60'd0, os_rd[11:8]};
            p_in     = sub_r;
            sidx_in  = '0;
            found_in = 1'b0;
            phase_in = 1'b0;
            state_in = (os_rd[14:12] == KIND_INT) ? ST_SEARCH : ST_CALC;
         end
         // look for a kept entry that starts at the target
         ST_SEARCH: begin
            if (!phase_ff) begin
               if (sidx_ff == kept_ff) state_in = ST_CALC;
               else phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (saddr_rd == tgt_rd) begin
                  found_in = 1'b1;
                  jofs_in  = so_rd;
                  state_in = ST_CALC;
               end else begin
                  sidx_in = sidx_ff + 1'b1;
               end
            end
         end
         // build the result item
         ST_CALC: begin
            lo_v = attr_rd.b0;
            hi_v = attr_rd.b1;
            case (kind_ff)
               KIND_PLAIN: pos_v = '0;
               KIND_INT: begin
                  pos_v = attr_rd.ipos;
                  if (!found_ff) st_v = STAT_MISSING;
                  else val_v = {{24{d8[7]}}, d8};
               end
               default: begin
                  if (s_chk == 64'd0 || s_chk > 64'hFFFF_FFFE) st_v = STAT_RANGE;
                  else val_v = p_ff[31:0];
                  case (kind_ff)
                     KIND_RIP:  pos_v = attr_rd.dpos;
                     KIND_NEAR: pos_v = attr_rd.ipos;
                     KIND_JMP: begin
                        pos_v = 4'd1; lo_v = OP_JMP32; hi_v = '0;
                     end
                     default: begin
                        pos_v = 4'd2; lo_v = OP_ESC; hi_v = attr_rd.b0 + OP_ADD10;
                     end
                  endcase
               end
            endcase
            if (st_v == STAT_OK) rel_v = rel_ff + {4'd0, nl_ff};
            else val_v = '0;
            rel_in   = rel_v;
            out_in   = {rel_v, total_ff, st_v, hi_v, lo_v, val_v, pos_v, nl_ff,
                        kind_ff, toff_ff, idx_ff};
            olast_in = (st_v != STAT_OK) || (idx_ff + 1'b1 == kept_ff);
            oidx_in  = idx_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (olast_ff) begin
                  count_in = '0;
                  total_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = oidx_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         base_ff  <= '0;
         count_ff <= '0;
         total_ff <= '0;
         kept_ff  <= '0;
         idx_ff   <= '0;
         sidx_ff  <= '0;
         phase_ff <= 1'b0;
         olast_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
         count_ff <= count_in;
         total_ff <= total_in;
         kept_ff  <= kept_in;
         idx_ff   <= idx_in;
         sidx_ff  <= sidx_in;
         phase_ff <= phase_in;
         olast_ff <= olast_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      rel_ff   <= rel_in;
      start_ff <= start_in;
      p_ff     <= p_in;
      kind_ff  <= kind_in;
      nl_ff    <= nl_in;
      toff_ff  <= toff_in;
      jofs_ff  <= jofs_in;
      found_ff <= found_in;
      out_ff   <= out_in;
      oidx_ff  <= oidx_in;
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = olast_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("load and result overlap");
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= 5'(KEEP_LIMIT)) else $error("kept count over limit");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_INSTS)) else $error("store count over depth");
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && count_ff == '0)
      else $error("run did not empty the store");

endmodule

@@ bench/x86_prologue_relocator_test.sv @@
// x86_prologue_relocator_test: self-checking bench for the prologue relocator
// depends on x86pr_pkg and the x86_prologue_relocator rtl
// directed table then random loads, checked against a behavioral planner
`timescale 1ns / 100ps

module x86_prologue_relocator_test;
   import x86pr_pkg::*;

   localparam int STORE_DEPTH = 32;
   localparam int MIN_BYTES   = 14;
   localparam int WATCH_LIMIT = 20000;

   // decoded instruction
   typedef struct packed {
      logic [63:0] addr;
      logic [3:0]  len;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic        rip;
      logic [31:0] disp;
      logic [63:0] target;
      logic [3:0]  dpos;
      logic [3:0]  ipos;
      logic        last;
   } inst_type;

   // relocation plan entry
   typedef struct packed {
      logic [4:0]  idx;
      logic [7:0]  off;
      logic [2:0]  kind;
      logic [3:0]  nlen;
      logic [3:0]  pos;
      logic [31:0] val;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [1:0]  status;
      logic [5:0]  stolen;
      logic [7:0]  rel;
      logic        last;
   } plan_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [63:0]  csr_wr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic         rsp_tlast;

   x86_prologue_relocator u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // planner state
   logic [63:0] reloc_base;
   inst_type    held_insts[$];
   plan_type    pending_plans[$];

   int  error_count = 0;
   int  items_sent = 0;
   int  plans_checked = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold = 1'b0;
   int  quiet_cycles = 0;

   function automatic bit branch_op(logic [7:0] b0, logic [7:0] b1);
      return b0 == OP_CALL || b0 == OP_JMP8 || b0 == OP_JMP32 ||
             (b0 >= 8'h70 && b0 <= 8'h7F) ||
             (b0 == OP_ESC && b1 >= 8'h80 && b1 <= 8'h8F);
   endfunction

   // store an instruction and, on the last one, plan the relocation
   task automatic plan_relocation(input inst_type it);
      logic [63:0] tgt[$];
      logic [2:0]  kinds[KEEP_LIMIT];
      logic [3:0]  nlens[KEEP_LIMIT];
      logic [7:0]  offs[KEEP_LIMIT];
      logic [63:0] start, stop, p, s;
      int          kept, total, off, rel, j;
      plan_type    r;
      inst_type    e;
      if (held_insts.size() < STORE_DEPTH) held_insts.push_back(it);
      if (!it.last) return;
      kept = 0;
      total = 0;
      while (kept < held_insts.size() && kept < KEEP_LIMIT && total < MIN_BYTES) begin
         total += held_insts[kept].len;
         kept++;
      end
      if (total < MIN_BYTES) begin
         r = '{default: '0};
         r.status = STAT_SHORT;
         r.stolen = 6'(total);
         r.last = 1'b1;
         pending_plans.push_back(r);
         held_insts.delete();
         return;
      end
      start = held_insts[0].addr;
      stop = start + 64'(total);
      off = 0;
      for (int i = 0; i < kept; i++) begin
         e = held_insts[i];
         tgt.push_back(e.rip ? e.addr + e.len + {{32{e.disp[31]}}, e.disp} : e.target);
         nlens[i] = e.len;
         if (e.rip) kinds[i] = KIND_RIP;
         else if (branch_op(e.b0, e.b1)) begin
            if (tgt[i] >= start && tgt[i] < stop) kinds[i] = KIND_INT;
            else if (e.b0 == OP_JMP8) begin kinds[i] = KIND_JMP; nlens[i] = 4'd5; end
            else if (e.b0 >= 8'h70 && e.b0 <= 8'h7F) begin
               kinds[i] = KIND_JCC;
               nlens[i] = 4'd6;
            end else kinds[i] = KIND_NEAR;
         end else kinds[i] = KIND_PLAIN;
         offs[i] = off[7:0];
         off += nlens[i];
      end
      rel = 0;
      for (int i = 0; i < kept; i++) begin
         e = held_insts[i];
         r = '{default: '0};
         r.idx = 5'(i);
         r.off = offs[i];
         r.kind = kinds[i];
         r.nlen = nlens[i];
         r.lo = e.b0;
         r.hi = e.b1;
         r.stolen = 6'(total);
         if (kinds[i] == KIND_INT) begin
            r.pos = e.ipos;
            for (j = 0; j < kept; j++) if (held_insts[j].addr == tgt[i]) break;
            if (j == kept) r.status = STAT_MISSING;
            else r.val = {{24{1'b0}}, offs[j] - (offs[i] + 8'(nlens[i]))};
            if (j != kept) r.val = {{24{r.val[7]}}, r.val[7:0]};
         end else if (kinds[i] != KIND_PLAIN) begin
            p = tgt[i] - (reloc_base + offs[i] + nlens[i]);
            s = p + 64'h8000_0000;
            if (s == 0 || s > 64'hFFFF_FFFE) r.status = STAT_RANGE;
            else r.val = p[31:0];
            case (kinds[i])
               KIND_RIP: r.pos = e.dpos;
               KIND_NEAR: r.pos = e.ipos;
               KIND_JMP: begin r.pos = 4'd1; r.lo = OP_JMP32; r.hi = '0; end
               default: begin r.pos = 4'd2; r.lo = OP_ESC; r.hi = e.b0 + OP_ADD10; end
            endcase
         end
         if (r.status == STAT_OK) rel += nlens[i];
         else r.val = '0;
         r.rel = 8'(rel);
         r.last = (r.status != STAT_OK) || (i + 1 == kept);
         pending_plans.push_back(r);
         if (r.status != STAT_OK) break;
      end
      held_insts.delete();
   endtask

   // drive one instruction and wait for its acceptance; valid drops only when idling
   task automatic send_inst(input inst_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'd0, it.ipos, it.dpos, it.target, it.disp, it.rip,
                    it.b1, it.b0, it.len, it.addr};
      req_tlast <= it.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      plan_relocation(it);
      items_sent++;
   endtask

   task automatic drain_plans();
      req_tvalid <= 1'b0;
      while (pending_plans.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_base(input logic [63:0] v);
      drain_plans();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reloc_base = v;
   endtask

   function automatic inst_type mk(logic [63:0] a, logic [3:0] l, logic [7:0] b0,
                                   logic [7:0] b1, logic rip, logic [31:0] d,
                                   logic [63:0] t, logic last);
      inst_type r;
      r.addr = a; r.len = l; r.b0 = b0; r.b1 = b1; r.rip = rip; r.disp = d;
      r.target = t; r.dpos = 4'($urandom_range(15)); r.ipos = 4'($urandom_range(15));
      r.last = last;
      return r;
   endfunction

   // random well-formed prologue with chained addresses
   task automatic send_prologue();
      logic [63:0] a, base;
      int          n, sel;
      logic [3:0]  l;
      logic [7:0]  b0, b1;
      logic [63:0] t;
      a = {$urandom, $urandom};
      if ($urandom_range(3) == 0) a = {32'h0, $urandom};
      base = a;
      n = $urandom_range(2, 8);
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(7);
         l = 4'($urandom_range(1, 7));
         b0 = 8'($urandom);
         b1 = 8'($urandom);
         case (sel)
            0: b0 = OP_JMP8;
            1: b0 = 8'h70 + 8'($urandom_range(15));
            2: b0 = OP_CALL;
            3: begin b0 = OP_ESC; b1 = 8'h80 + 8'($urandom_range(15)); end
            default: if (branch_op(b0, b1)) b0 = 8'h90;
         endcase
         case ($urandom_range(3))
            0: t = base + 64'($urandom_range(20));
            1: t = reloc_base + 64'($urandom_range(1000)) - 64'd500;
            2: t = a + {{32{1'b0}}, $urandom};
            default: t = {$urandom, $urandom};
         endcase
         send_inst(mk(a, l, b0, b1, $urandom_range(4) == 0, $urandom, t, i == n - 1));
         a += 64'(l);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      plan_type    x;
      logic [87:0] exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         quiet_cycles <= 0;
         if (pending_plans.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, rsp_tdata);
            error_count++;
         end else begin
            x = pending_plans.pop_front();
            plans_checked++;
            exp_word = {x.rel, x.stolen, x.status, x.hi, x.lo, x.val, x.pos,
                        x.nlen, x.kind, x.off, x.idx};
            if (rsp_tdata !== exp_word || rsp_tlast !== x.last) begin
               $display("%0t: expected %h last %b, actual %h last %b",
                        $realtime, exp_word, x.last, rsp_tdata, rsp_tlast);
               error_count++;
            end
         end
      end else if (req_tvalid && req_tready) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // receiver ready
   always @(posedge clock) begin
      if (reset || recv_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles > WATCH_LIMIT) begin
         $display("%0t: watchdog expired", $realtime);
         $display("Mismatches found");
         $finish;
      end
   end

   // directed rows; expected value given where obvious
   typedef struct {
      inst_type it;
      bit       has_exp;
      plan_type exp;
   } row_type;

   initial begin
      row_type  rows[$];
      row_type  w;
      plan_type sh;
      inst_type it;
      reloc_base = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sh = '{default: '0};
      sh.status = STAT_SHORT;
      sh.last = 1'b1;
      // single short instruction after reset
      w.it = mk(64'h0, 4'd3, 8'h55, 8'h00, 1'b0, 32'd0, 64'd0, 1'b1);
      w.has_exp = 1'b1; w.exp = sh; w.exp.stolen = 6'd3; rows.push_back(w);
      // zero length and extreme address
      w.it = mk('1, 4'd0, 8'hFF, 8'hFF, 1'b1, 32'h8000_0000, '1, 1'b1);
      w.exp.stolen = 6'd0; rows.push_back(w);
      w.has_exp = 1'b0;
      // jmp8, jcc, call, 0F 8x, rip, internal branch in one prologue
      w.it = mk(64'h1000, 4'd2, OP_JMP8, 8'h00, 1'b0, 32'd0, 64'h9000, 1'b0);
      rows.push_back(w);
      w.it = mk(64'h1002, 4'd2, 8'h74, 8'h00, 1'b0, 32'd0, 64'h8000, 1'b0);
      rows.push_back(w);
      w.it = mk(64'h1004, 4'd5, OP_CALL, 8'h00, 1'b0, 32'd0, 64'h7000, 1'b0);
      rows.push_back(w);
      w.it = mk(64'h1009, 4'd6, OP_ESC, 8'h85, 1'b0, 32'd0, 64'h1000, 1'b0);
      rows.push_back(w);
      w.it = mk(64'h100F, 4'd7, 8'h8B, 8'h05, 1'b1, 32'hFFFF_FF00, 64'd0, 1'b1);
      rows.push_back(w);
      // internal branch with missing target
      w.it = mk(64'h2000, 4'd2, 8'h7F, 8'h00, 1'b0, 32'd0, 64'h2001, 1'b0);
      rows.push_back(w);
      w.it = mk(64'h2002, 4'd15, 8'h90, 8'h00, 1'b0, 32'd0, 64'd0, 1'b1);
      rows.push_back(w);
      // range error on far call
      w.it = mk(64'h3000, 4'd5, OP_CALL, 8'h00, 1'b0, 32'd0, 64'hFFFF_0000_0000_0000,
                1'b0);
      rows.push_back(w);
      w.it = mk(64'h3005, 4'd15, OP_JMP32, 8'h00, 1'b0, 32'd0, 64'h3000, 1'b1);
      rows.push_back(w);
      // keep limit: 14 one-byte instructions
      for (int i = 0; i < 14; i++) begin
         w.it = mk(64'h4000 + 64'(i), 4'd1, 8'h90, 8'h00, 1'b0, 32'd0, 64'd0, i == 13);
         rows.push_back(w);
      end
      foreach (rows[i]) begin
         if (rows[i].has_exp) begin
            drain_plans();
            send_inst(rows[i].it);
            if (pending_plans.size() != 1 || pending_plans[0] != rows[i].exp) begin
               $display("%0t: directed row %0d planner disagrees with table", $realtime, i);
               error_count++;
            end
         end else send_inst(rows[i].it);
      end

      // store overflow: 34 items, last dropped but ends the load
      for (int i = 0; i < 34; i++)
         send_inst(mk(64'h5000 + 64'(i), 4'd1, 8'h90, 8'h00, 1'b0, 32'd0, 64'd0, i == 33));

      // random phases over several bases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_base(64'h0);
            1: write_base('1);
            2: write_base({$urandom, $urandom});
            default: write_base(64'h1000);
         endcase
         if (ph == 0) begin send_idle_pct = 38; recv_idle_pct = 61; end
         else if (ph == 1) begin send_idle_pct = 61; recv_idle_pct = 38; end
         else begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (ph == 2) begin
            // receiver holds off while the sender keeps going
            fork
               begin
                  recv_hold = 1'b1;
                  repeat (400) @(posedge clock);
                  recv_hold = 1'b0;
               end
               repeat (6) send_prologue();
            join
         end
         while (items_sent < 75 + ph * 50) begin
            if ($urandom_range(9) == 0) begin
               it = mk({$urandom, $urandom}, 4'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom), $urandom, {$urandom, $urandom},
                       $urandom_range(3) == 0);
               send_inst(it);
            end else send_prologue();
         end
         if (ph == 3) begin
            it = mk(64'h0, 4'd1, 8'h90, 8'h00, 1'b0, 32'd0, 64'd0, 1'b1);
            send_inst(it);
         end
      end
      drain_plans();
      $display("covered %0d instructions and %0d relocation results over 4 base settings",
               items_sent, plans_checked);
      if (error_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
